@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the RTL of the list engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/ile_pkg.sv @@
// ----------------------------------------------------------------------------
// ile_pkg
// Field widths, operation codes and sequencer states of the list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned COUNT_W = 11;

  // Operation codes; the remaining codes are refused.
  typedef enum logic [OP_W-1:0] {
    OP_READ     = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_INS_AT   = 3'd3,
    OP_DELETE   = 3'd4
  } op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_SHIFT_UP,
    ST_PUT,
    ST_SHIFT_DN,
    ST_DONE
  } state_t;

endpackage

@@ design/indexed_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// indexed_list_engine_unit
// Ordered list of up to CAPACITY values in one single-port-write memory,
// with read, insert and delete by position, one result word per input word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries op, position and item_value.
//   Output channel (out_valid/out_ready) carries read_value, found, accepted
//   and entry_count, one result word for every input word.
//   The block works on one word at a time; in_ready is high only while idle.
//   A read goes from idle through ST_RD_WAIT to the result; an insert walks
//   the tail up in ST_SHIFT_UP, then writes the new entry in ST_PUT; a
//   delete walks the tail down in ST_SHIFT_DN; a refused operation goes
//   straight to the result.
//   Inserts and deletes move the tail of the list one entry per cycle
//   through the memory: one read and one write per cycle, with a single
//   cursor counter and comparator doing the walk. Worst case is an insert
//   at the head of a list of CAPACITY-1 entries.
//   A result is held in the output register while out_ready is low; no new
//   word is taken until it leaves.
//   Reset empties the list at once; memory contents are not cleared, and
//   only positions below the entry count are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_list_engine_unit #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ile_pkg::OP_W-1:0]      op,
  input  logic [ile_pkg::POS_W-1:0]     position,
  input  logic [ile_pkg::VALUE_W-1:0]   item_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ile_pkg::VALUE_W-1:0]   read_value,
  output logic                          found,
  output logic                          accepted,
  output logic [ile_pkg::COUNT_W-1:0]   entry_count
);

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned LEN_W  = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = (LEN_W > ile_pkg::POS_W) ? LEN_W : ile_pkg::POS_W;
  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

  // Entry storage.
  logic [ile_pkg::VALUE_W-1:0] mem [CAPACITY];

  ile_pkg::state_t             state, state_next;
  logic [LEN_W-1:0]            length, length_next;
  logic [LEN_W-1:0]            cur, cur_next;
  logic [LEN_W-1:0]            target, target_next;
  logic                        pend, pend_next;
  logic [ADDR_W-1:0]           pend_addr, pend_addr_next;
  logic [ile_pkg::VALUE_W-1:0] stash, stash_next;
  logic [ile_pkg::VALUE_W-1:0] out_value, out_value_next;
  logic                        out_found, out_found_next;
  logic                        out_accepted, out_accepted_next;

  logic                        rd_en;
  logic [ADDR_W-1:0]           rd_addr;
  logic [ile_pkg::VALUE_W-1:0] rd_data;
  logic                        we;
  logic [ADDR_W-1:0]           wr_addr;
  logic [ile_pkg::VALUE_W-1:0] wr_data;

  logic [CMP_W-1:0]            pos_ext;
  logic [CMP_W-1:0]            len_ext;
  logic                        full;
  logic [LEN_W-1:0]            cur_dec;
  logic [LEN_W-1:0]            cur_inc;
  logic [LEN_W-1:0]            pos_inc;

  assign pos_ext = CMP_W'(position);
  assign len_ext = CMP_W'(length);
  assign full    = (length == CAP_LEN);
  assign cur_dec = cur - LEN_W'(1);
  assign cur_inc = cur + LEN_W'(1);
  assign pos_inc = pos_ext[LEN_W-1:0] + LEN_W'(1);

  assign in_ready    = (state == ile_pkg::ST_IDLE);
  assign out_valid   = (state == ile_pkg::ST_DONE);
  assign read_value  = out_value;
  assign found       = out_found;
  assign accepted    = out_accepted;
  assign entry_count = len_ext[ile_pkg::COUNT_W-1:0];

  // Hold the sequencer and list length.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ile_pkg::ST_IDLE;
      length <= '0;
      pend   <= 1'b0;
    end else begin
      state  <= state_next;
      length <= length_next;
      pend   <= pend_next;
    end
  end

  // Advance the walk and result payload.
  always_ff @(posedge clk) begin
    cur          <= cur_next;
    target       <= target_next;
    pend_addr    <= pend_addr_next;
    stash        <= stash_next;
    out_value    <= out_value_next;
    out_found    <= out_found_next;
    out_accepted <= out_accepted_next;
  end

  // Memory write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Memory read port, registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Decode the word, then walk the tail of the list one entry per cycle.
  always_comb begin
    state_next        = state;
    length_next       = length;
    cur_next          = cur;
    target_next       = target;
    pend_next         = pend;
    pend_addr_next    = pend_addr;
    stash_next        = stash;
    out_value_next    = out_value;
    out_found_next    = out_found;
    out_accepted_next = out_accepted;
    rd_en             = 1'b0;
    rd_addr           = cur_dec[ADDR_W-1:0];
    we                = 1'b0;
    wr_addr           = pend_addr;
    wr_data           = rd_data;

    unique case (state)
      ile_pkg::ST_IDLE: begin
        // Refused unless an arm below takes the word.
        out_value_next    = '0;
        out_found_next    = 1'b0;
        out_accepted_next = 1'b0;
        pend_next         = 1'b0;
        stash_next        = item_value;
        if (in_valid) begin
          state_next = ile_pkg::ST_DONE;
          unique case (ile_pkg::op_t'(op))
            ile_pkg::OP_READ: begin
              if (pos_ext < len_ext) begin
                rd_en      = 1'b1;
                rd_addr    = pos_ext[ADDR_W-1:0];
                state_next = ile_pkg::ST_RD_WAIT;
              end
            end
            ile_pkg::OP_INS_HEAD: begin
              if (!full) begin
                target_next = '0;
                cur_next    = length;
                state_next  = ile_pkg::ST_SHIFT_UP;
              end
            end
            ile_pkg::OP_INS_TAIL: begin
              if (!full) begin
                target_next = length;
                cur_next    = length;
                state_next  = ile_pkg::ST_SHIFT_UP;
              end
            end
            ile_pkg::OP_INS_AT: begin
              if (!full && (pos_ext <= len_ext)) begin
                target_next = pos_ext[LEN_W-1:0];
                cur_next    = length;
                state_next  = ile_pkg::ST_SHIFT_UP;
              end
            end
            ile_pkg::OP_DELETE: begin
              if (pos_ext < len_ext) begin
                cur_next   = pos_inc;
                state_next = ile_pkg::ST_SHIFT_DN;
              end
            end
            default: begin
              state_next = ile_pkg::ST_DONE;
            end
          endcase
        end
      end

      ile_pkg::ST_RD_WAIT: begin
        out_value_next    = rd_data;
        out_found_next    = 1'b1;
        out_accepted_next = 1'b1;
        state_next        = ile_pkg::ST_DONE;
      end

      ile_pkg::ST_SHIFT_UP: begin
        // Write the entry read last cycle one place higher.
        we = pend;
        if (cur > target) begin
          rd_en          = 1'b1;
          rd_addr        = cur_dec[ADDR_W-1:0];
          pend_next      = 1'b1;
          pend_addr_next = cur[ADDR_W-1:0];
          cur_next       = cur_dec;
        end else begin
          pend_next  = 1'b0;
          state_next = ile_pkg::ST_PUT;
        end
      end

      ile_pkg::ST_PUT: begin
        we                = 1'b1;
        wr_addr           = target[ADDR_W-1:0];
        wr_data           = stash;
        length_next       = length + LEN_W'(1);
        out_accepted_next = 1'b1;
        state_next        = ile_pkg::ST_DONE;
      end

      ile_pkg::ST_SHIFT_DN: begin
        // Write the entry read last cycle one place lower.
        we = pend;
        if (cur < length) begin
          rd_en          = 1'b1;
          rd_addr        = cur[ADDR_W-1:0];
          pend_next      = 1'b1;
          pend_addr_next = cur_dec[ADDR_W-1:0];
          cur_next       = cur_inc;
        end else begin
          pend_next         = 1'b0;
          length_next       = length - LEN_W'(1);
          out_accepted_next = 1'b1;
          state_next        = ile_pkg::ST_DONE;
        end
      end

      ile_pkg::ST_DONE: begin
        if (out_ready) begin
          state_next = ile_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = ile_pkg::ST_IDLE;
      end
    endcase
  end

  `ASSERT_CLK(a_len_bound, length <= CAP_LEN, "list length exceeds capacity")

  `ASSERT_CLK(a_one_side, !(in_ready && out_valid), "input and output open together")

  `ASSERT_CLK(a_refused_keeps_len, $rose(out_valid) && !out_accepted |-> $stable(length),
              "refused operation changed the list length")

  `ASSERT_CLK(a_write_in_walk, we |-> (state == ile_pkg::ST_SHIFT_UP ||
              state == ile_pkg::ST_SHIFT_DN || state == ile_pkg::ST_PUT),
              "memory written outside an insert or delete")

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed list engine. A shadow list held in a
// queue predicts every result word. A short table of directed words comes
// first, then random traffic on short lists, a fill to capacity and a
// stretch of random words on the full list. Both channels idle and stall at
// random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OP_W    = ile_pkg::OP_W;
  localparam int unsigned POS_W   = ile_pkg::POS_W;
  localparam int unsigned VALUE_W = ile_pkg::VALUE_W;
  localparam int unsigned COUNT_W = ile_pkg::COUNT_W;

  localparam int unsigned LIST_CAPACITY = 1024;
  localparam int unsigned SHORT_WORDS   = 560;
  localparam int unsigned FULL_WORDS    = 40;
  localparam int unsigned DRAIN_CYCLES  = 1100;
  localparam int unsigned MAX_GAP       = 17;

  // Codes outside the op_t set; the engine refuses them.
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               found;
    logic               accepted;
    logic [COUNT_W-1:0] entry_count;
  } list_result_t;

  typedef struct packed {
    logic [OP_W-1:0]    code;
    logic [POS_W-1:0]   where;
    logic [VALUE_W-1:0] data;
    logic               typed;
    list_result_t       want;
  } list_cmd_t;

  localparam list_result_t FROM_SHADOW = '0;

  // Directed words; rows with typed set carry their own expected result.
  localparam int unsigned DIRECTED_N = 24;
  localparam list_cmd_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{ile_pkg::OP_READ,     11'd0,    16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0, 11'd0}},
    '{ile_pkg::OP_DELETE,   11'd0,    16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0, 11'd0}},
    '{ile_pkg::OP_INS_AT,   11'd1,    16'h5555, 1'b1, '{16'h0000, 1'b0, 1'b0, 11'd0}},
    '{OP_UNUSED_HI,         11'd2047, 16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b0, 11'd0}},
    '{ile_pkg::OP_INS_HEAD, 11'd0,    16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b1, 11'd1}},
    '{ile_pkg::OP_INS_TAIL, 11'd2047, 16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b1, 11'd2}},
    '{ile_pkg::OP_READ,     11'd0,    16'h0000, 1'b1, '{16'hFFFF, 1'b1, 1'b1, 11'd2}},
    '{ile_pkg::OP_READ,     11'd1,    16'hFFFF, 1'b1, '{16'h0000, 1'b1, 1'b1, 11'd2}},
    '{ile_pkg::OP_READ,     11'd2,    16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0, 11'd2}},
    '{ile_pkg::OP_INS_AT,   11'd0,    16'h1234, 1'b0, FROM_SHADOW},
    '{ile_pkg::OP_READ,     11'd0,    16'h0000, 1'b0, FROM_SHADOW},
    '{ile_pkg::OP_INS_AT,   11'd3,    16'h8001, 1'b0, FROM_SHADOW},
    '{ile_pkg::OP_READ,     11'd3,    16'h0000, 1'b0, FROM_SHADOW},
    '{ile_pkg::OP_INS_AT,   11'd5,    16'hAAAA, 1'b0, FROM_SHADOW},
    '{ile_pkg::OP_READ,     11'd2047, 16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0, 11'd4}},
    '{ile_pkg::OP_DELETE,   11'd2047, 16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0, 11'd4}},
    '{ile_pkg::OP_INS_AT,   11'd2047, 16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b0, 11'd4}},
    '{OP_UNUSED_LO,         11'd1024, 16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0, 11'd4}},
    '{ile_pkg::OP_READ,     11'd1024, 16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0, 11'd4}},
    '{ile_pkg::OP_DELETE,   11'd1,    16'h0000, 1'b0, FROM_SHADOW},
    '{ile_pkg::OP_INS_AT,   11'd2,    16'h00FF, 1'b0, FROM_SHADOW},
    '{ile_pkg::OP_DELETE,   11'd0,    16'h0000, 1'b0, FROM_SHADOW},
    '{ile_pkg::OP_DELETE,   11'd2,    16'h0000, 1'b0, FROM_SHADOW},
    '{ile_pkg::OP_READ,     11'd1,    16'h0000, 1'b0, FROM_SHADOW}
  };

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    op         = '0;
  logic [POS_W-1:0]   position   = '0;
  logic [VALUE_W-1:0] item_value = '0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [VALUE_W-1:0] read_value;
  logic               found;
  logic               accepted;
  logic [COUNT_W-1:0] entry_count;

  logic [VALUE_W-1:0] shadow_list[$];
  list_result_t       awaited_results[$];

  int unsigned mismatch_count  = 0;
  int unsigned results_checked = 0;
  int unsigned words_sent      = 0;
  int unsigned words_refused   = 0;
  int unsigned peak_length     = 0;
  int unsigned send_calm       = 0;
  int unsigned recv_calm       = 0;

  indexed_list_engine_unit #(
    .CAPACITY (LIST_CAPACITY)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .position    (position),
    .item_value  (item_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_value  (read_value),
    .found       (found),
    .accepted    (accepted),
    .entry_count (entry_count)
  );

  always #5 clk = ~clk;

  // Apply one operation to the shadow list and return its result word.
  function automatic list_result_t predict_list_op(input logic [OP_W-1:0] code,
                                                   input logic [POS_W-1:0] where,
                                                   input logic [VALUE_W-1:0] data);
    list_result_t res;
    int unsigned  n;
    res = '0;
    n   = shadow_list.size();
    case (code)
      ile_pkg::OP_READ: begin
        if (where < n) begin
          res.read_value = shadow_list[where];
          res.found      = 1'b1;
          res.accepted   = 1'b1;
        end
      end
      ile_pkg::OP_INS_HEAD: begin
        if (n < LIST_CAPACITY) begin
          shadow_list.push_front(data);
          res.accepted = 1'b1;
        end
      end
      ile_pkg::OP_INS_TAIL: begin
        if (n < LIST_CAPACITY) begin
          shadow_list.push_back(data);
          res.accepted = 1'b1;
        end
      end
      ile_pkg::OP_INS_AT: begin
        if (n < LIST_CAPACITY && where <= n) begin
          shadow_list.insert(where, data);
          res.accepted = 1'b1;
        end
      end
      ile_pkg::OP_DELETE: begin
        if (where < n) begin
          shadow_list.delete(where);
          res.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    res.entry_count = COUNT_W'(shadow_list.size());
    return res;
  endfunction

  // Pick a position: mostly inside the list, often on its edges, sometimes anywhere.
  function automatic logic [POS_W-1:0] draw_position(input int unsigned n);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)      return POS_W'($urandom_range(0, n));
    else if (r < 75) return POS_W'(n + $urandom_range(0, 2) - ((n > 0) ? 1 : 0));
    else if (r < 85) return '0;
    else             return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  function automatic logic [VALUE_W-1:0] draw_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10)      return '1;
    else if (r < 20) return '0;
    else             return VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Offer one word, hold it until taken, then log its expected result.
  task automatic send_word(input logic [OP_W-1:0] code, input logic [POS_W-1:0] where,
                           input logic [VALUE_W-1:0] data, input logic typed,
                           input list_result_t want);
    int unsigned  gap;
    list_result_t pred;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      send_calm = $urandom_range(8, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= code;
    position   <= where;
    item_value <= data;
    do @(posedge clk); while (!in_ready);
    pred = predict_list_op(code, where, data);
    awaited_results.push_back(typed ? want : pred);
    words_sent++;
    if (!pred.accepted) words_refused++;
    if (shadow_list.size() > peak_length) peak_length = shadow_list.size();
  endtask

  // Drop valid and wait until every result word is back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // Stimulus
  initial begin
    int unsigned       n;
    int unsigned       r;
    int unsigned       grow;
    logic [OP_W-1:0]   code;
    logic [POS_W-1:0]  where;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    foreach (DIRECTED_ROWS[i]) begin
      send_word(DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].where, DIRECTED_ROWS[i].data,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    // Random traffic on short lists; steer the length between a few and ~40.
    for (int k = 0; k < SHORT_WORDS; k++) begin
      n = shadow_list.size();
      r = $urandom_range(0, 99);
      grow = (n < 10) ? 80 : ((n > 40) ? 25 : 50);
      if (r < 4) begin
        code = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end else if (r < 30) begin
        code = ile_pkg::OP_READ;
      end else if ($urandom_range(0, 99) < grow) begin
        code = OP_W'($urandom_range(ile_pkg::OP_INS_HEAD, ile_pkg::OP_INS_AT));
      end else begin
        code = ile_pkg::OP_DELETE;
      end
      if ($urandom_range(0, 39) == 0) hold_until_drained();
      send_word(code, draw_position(n), draw_value(), 1'b0, FROM_SHADOW);
    end

    // Fill to capacity, mostly at the tail so each word stays short.
    hold_until_drained();
    while (shadow_list.size() < LIST_CAPACITY) begin
      n = shadow_list.size();
      if ($urandom_range(0, 99) < 75) begin
        code  = ile_pkg::OP_INS_TAIL;
        where = POS_W'($urandom_range(0, (1 << POS_W) - 1));
      end else begin
        code  = ile_pkg::OP_INS_AT;
        where = POS_W'($urandom_range((n > 4) ? n - 4 : 0, n));
      end
      send_word(code, where, draw_value(), 1'b0, FROM_SHADOW);
    end

    // Work on the full list; open with one insert of each kind.
    for (int k = 0; k < FULL_WORDS; k++) begin
      if (k < 3) code = OP_W'(ile_pkg::OP_INS_HEAD + k);
      else       code = OP_W'($urandom_range(ile_pkg::OP_READ, OP_UNUSED_HI));
      send_word(code, draw_position(shadow_list.size()), draw_value(), 1'b0, FROM_SHADOW);
    end

    // Let the last words drain, then watch for stray results.
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words (%0d refused), list length peaked at %0d of %0d.",
             words_sent, words_refused, peak_length, LIST_CAPACITY);
    $display("Checked %0d result words, %0d mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: stall at random, compare each word with the oldest expectation.
  initial begin
    int unsigned  stall;
    list_result_t got;
    list_result_t want;

    while (rst) @(posedge clk);
    forever begin
      if (recv_calm > 0) begin
        recv_calm--;
        stall = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        recv_calm = $urandom_range(8, 40);
        stall = 0;
      end else begin
        stall = $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = {read_value, found, accepted, entry_count};
      results_checked++;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result word %0d arrived with nothing expected",
                                  results_checked));
      end else begin
        want = awaited_results.pop_front();
        if (got.read_value !== want.read_value)
          report_mismatch($sformatf("word %0d read_value exp %h got %h",
                                    results_checked, want.read_value, got.read_value));
        if (got.found !== want.found)
          report_mismatch($sformatf("word %0d found exp %b got %b",
                                    results_checked, want.found, got.found));
        if (got.accepted !== want.accepted)
          report_mismatch($sformatf("word %0d accepted exp %b got %b",
                                    results_checked, want.accepted, got.accepted));
        if (got.entry_count !== want.entry_count)
          report_mismatch($sformatf("word %0d entry_count exp %0d got %0d",
                                    results_checked, want.entry_count, got.entry_count));
      end
    end
  end

  // Stop a hung run.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
